@@ src/ops_pkg.sv @@
// ----------------------------------------------------------------------------
// ops_pkg
// Shared types and constants of the octave pitch shifter.
// ----------------------------------------------------------------------------
package ops_pkg;

  localparam int SAMPLE_W = 12;
  localparam int PHASE_W  = 11;
  localparam int DLY_W    = 13;

  // delay geometry
  localparam int UP_SPAN   = 2048;
  localparam int MAX_DELAY = 2 * UP_SPAN;
  localparam logic [PHASE_W-1:0] FADE_SPAN = PHASE_W'(1024);
  localparam int FRAC_SHIFT = 10;

  // shared multiply-accumulate unit
  localparam int MUL_X_W = 14;
  localparam int MUL_Y_W = 18;
  localparam int ACC_W   = 32;

  // divide by voice count: multiply by 2^17 / count, then shift
  localparam int RECIP_SHIFT = 17;
  localparam logic [MUL_Y_W-1:0] RECIP_ONE   = MUL_Y_W'(131072);
  localparam logic [MUL_Y_W-1:0] RECIP_TWO   = MUL_Y_W'(65536);
  localparam logic [MUL_Y_W-1:0] RECIP_THREE = MUL_Y_W'(43691);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_ENABLE  = 2'd2;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD
  } mac_op_t;

  typedef struct packed {
    logic    en;
    mac_op_t op;
  } mac_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_UP_MAIN,
    ST_RD_UP_FADE,
    ST_RD_DN_MAIN,
    ST_RD_DN_FADE,
    ST_FADE_DN,
    ST_SUM_CLEAN,
    ST_SUM_UP,
    ST_SUM_DN,
    ST_SCALE,
    ST_DONE
  } state_t;

  function automatic logic [MUL_Y_W-1:0] recip(input logic [1:0] count);
    logic [MUL_Y_W-1:0] r;
    unique case (count)
      2'd1:    r = RECIP_ONE;
      2'd2:    r = RECIP_TWO;
      2'd3:    r = RECIP_THREE;
      default: r = RECIP_ONE;
    endcase
    return r;
  endfunction

endpackage

@@ src/ops_in_if.sv @@
// ----------------------------------------------------------------------------
// ops_in_if
// Input sample channel: valid/ready handshake with one sample per item.
// ----------------------------------------------------------------------------
interface ops_in_if;
  logic                         valid;
  logic                         ready;
  logic [ops_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

@@ src/ops_out_if.sv @@
// ----------------------------------------------------------------------------
// ops_out_if
// Output sample channel: valid/ready handshake with one mixed sample per item.
// ----------------------------------------------------------------------------
interface ops_out_if;
  logic                         valid;
  logic                         ready;
  logic [ops_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

@@ src/ops_ring.sv @@
// ----------------------------------------------------------------------------
// ops_ring
// Sample ring: one write port, one registered read port, fill count so that
// entries never written read as zero.
// ----------------------------------------------------------------------------
module ops_ring #(
  parameter int DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [ops_pkg::SAMPLE_W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [ops_pkg::SAMPLE_W-1:0] rdata
);

  localparam int FW = $clog2(DEPTH + 1);

  logic [ops_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [ops_pkg::SAMPLE_W-1:0] rd_q;
  logic                         hit_q;
  logic [FW-1:0]                fill;

  // writes go in order from entry 0, so entries below fill are written
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (we && (fill != FW'(DEPTH))) begin
      fill <= fill + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q  <= mem[raddr];
    hit_q <= (FW'(raddr) < fill);
  end

  assign rdata = hit_q ? rd_q : '0;

endmodule

@@ src/ops_mac.sv @@
// ----------------------------------------------------------------------------
// ops_mac
// Shared multiply-accumulate unit: load or accumulate one product per cycle when enabled.
// ----------------------------------------------------------------------------
module ops_mac (
  input  logic                        clk,
  input  ops_pkg::mac_cmd_t           cmd,
  input  logic [ops_pkg::MUL_X_W-1:0] x,
  input  logic [ops_pkg::MUL_Y_W-1:0] y,
  output logic [ops_pkg::ACC_W-1:0]   acc
);

  logic [ops_pkg::ACC_W-1:0] prod;

  assign prod = ops_pkg::ACC_W'(x) * ops_pkg::ACC_W'(y);

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      unique case (cmd.op)
        ops_pkg::MAC_LOAD: acc <= prod;
        ops_pkg::MAC_ADD:  acc <= acc + prod;
        default:           acc <= acc;
      endcase
    end
  end

endmodule

@@ src/octave_pitch_shifter.sv @@
// ----------------------------------------------------------------------------
// octave_pitch_shifter
// Delay-line octave up/down shifter with crossfaded taps and voice mixer.
// ----------------------------------------------------------------------------
// An input item is accepted only in the idle state, after the last result
//   is loaded; each item makes four ring reads through the single
//   read port and eight passes through the shared multiply-accumulate unit.
// Reset: pointer, phase, enables and output valid clear at once; the ring is
//   tracked by a fill count, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module octave_pitch_shifter #(
  parameter int RING_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ops_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ops_pkg::CFG_DATA_W-1:0] cfg_data,
  ops_in_if.sink                         samples,
  ops_out_if.source                      mixed
);

  localparam int AW    = $clog2(RING_DEPTH);
  // enough whole ring lengths to keep (ptr - 1 - delay) nonnegative
  localparam int WRAPS = (ops_pkg::MAX_DELAY + RING_DEPTH) / RING_DEPTH;
  localparam int X_W   = $clog2((WRAPS + 1) * RING_DEPTH);

  localparam int SW = ops_pkg::SAMPLE_W;
  localparam int PW = ops_pkg::PHASE_W;
  localparam int DW = ops_pkg::DLY_W;

  // ring index of a tap: (ptr - 1 - delay) mod depth, WRAPS compare/subtracts
  function automatic logic [AW-1:0] tap_index(input logic [AW-1:0] base,
                                              input logic [DW-1:0] dly);
    logic [X_W-1:0] x;
    x = X_W'(base) + X_W'(WRAPS * RING_DEPTH) - X_W'(dly) - X_W'(1);
    for (int k = 0; k < WRAPS; k++) begin
      if (x >= X_W'(RING_DEPTH)) x = x - X_W'(RING_DEPTH);
    end
    return x[AW-1:0];
  endfunction

  ops_pkg::state_t   state, state_next;
  ops_pkg::mac_cmd_t mac_cmd;

  logic [AW-1:0] wp, wp_next;
  logic [PW-1:0] phase;
  logic          up_en, clean_en, down_en;
  logic [1:0]    count;

  logic [SW-1:0] s_reg, upv, downv;
  logic          out_valid;
  logic [SW-1:0] out_data;
  logic          out_load;
  logic          accept;

  logic [PW-1:0] fade_t, fade_w;
  logic [DW-1:0] d_up_main, d_up_fade, d_dn_main, d_dn_fade, rd_dly;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] tap;

  logic [ops_pkg::MUL_X_W-1:0] mac_x;
  logic [ops_pkg::MUL_Y_W-1:0] mac_y;
  logic [ops_pkg::ACC_W-1:0]   acc;

  assign samples.ready = (state == ops_pkg::ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign mixed.valid      = out_valid;
  assign mixed.sample_out = out_data;

  assign wp_next = (wp == AW'(RING_DEPTH - 1)) ? '0 : wp + AW'(1);
  assign count   = {1'b0, up_en} + {1'b0, clean_en} + {1'b0, down_en};

  // Both voices start at phase zero and step together, so one phase counter
  // serves both. Fade position is zero outside the last 1024 steps, which
  // makes the fade weight the main tap fully.
  assign fade_t = (phase > ops_pkg::FADE_SPAN) ? phase - ops_pkg::FADE_SPAN : '0;
  assign fade_w = ops_pkg::FADE_SPAN - fade_t;

  assign d_up_main = DW'(ops_pkg::UP_SPAN) - DW'(phase);
  assign d_up_fade = DW'(ops_pkg::MAX_DELAY) - DW'(phase);
  assign d_dn_main = DW'(phase >> 1) + DW'(ops_pkg::FADE_SPAN);
  assign d_dn_fade = DW'(phase >> 1);

  assign rd_addr = tap_index(wp, rd_dly);

  ops_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .rst   (rst),
    .we    (accept),
    .waddr (wp),
    .wdata (samples.sample_in),
    .raddr (rd_addr),
    .rdata (tap)
  );

  ops_mac u_mac (
    .clk (clk),
    .cmd (mac_cmd),
    .x   (mac_x),
    .y   (mac_y),
    .acc (acc)
  );

  // config registers, only bit 0 kept; unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      up_en    <= 1'b0;
      clean_en <= 1'b0;
      down_en  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ops_pkg::CFG_UP_ENABLE:    up_en    <= cfg_data[0];
        ops_pkg::CFG_CLEAN_ENABLE: clean_en <= cfg_data[0];
        ops_pkg::CFG_DOWN_ENABLE:  down_en  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ops_pkg::ST_IDLE;
      wp        <= '0;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        wp <= wp_next;
      end
      if (out_load) begin
        phase     <= phase + PW'(1);
        out_valid <= 1'b1;
      end else if (mixed.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload captures
  always_ff @(posedge clk) begin
    if (accept) begin
      s_reg <= samples.sample_in;
    end
    if (state == ops_pkg::ST_RD_DN_FADE) begin
      upv <= acc[ops_pkg::FRAC_SHIFT +: SW];
    end
    if (state == ops_pkg::ST_SUM_CLEAN) begin
      downv <= acc[ops_pkg::FRAC_SHIFT +: SW];
    end
    if (out_load) begin
      out_data <= (count == 2'd0) ? s_reg : acc[ops_pkg::RECIP_SHIFT +: SW];
    end
  end

  // Sequencer: a tap address goes out one state, its data comes back the next
  // and feeds the MAC. Each voice is a*(1024-t) then +b*t, scaled by >>10.
  // The mix sums enabled voices times 2^17/count; with none, the input passes.
  always_comb begin
    state_next = state;
    rd_dly     = d_up_main;
    mac_cmd    = '{en: 1'b0, op: ops_pkg::MAC_LOAD};
    mac_x      = '0;
    mac_y      = '0;
    out_load   = 1'b0;
    unique case (state)
      ops_pkg::ST_IDLE: begin
        if (accept) state_next = ops_pkg::ST_RD_UP_MAIN;
      end
      ops_pkg::ST_RD_UP_MAIN: begin
        rd_dly     = d_up_main;
        state_next = ops_pkg::ST_RD_UP_FADE;
      end
      ops_pkg::ST_RD_UP_FADE: begin
        rd_dly     = d_up_fade;
        mac_cmd    = '{en: 1'b1, op: ops_pkg::MAC_LOAD};
        mac_x      = ops_pkg::MUL_X_W'(tap);
        mac_y      = ops_pkg::MUL_Y_W'(fade_w);
        state_next = ops_pkg::ST_RD_DN_MAIN;
      end
      ops_pkg::ST_RD_DN_MAIN: begin
        rd_dly     = d_dn_main;
        mac_cmd    = '{en: 1'b1, op: ops_pkg::MAC_ADD};
        mac_x      = ops_pkg::MUL_X_W'(tap);
        mac_y      = ops_pkg::MUL_Y_W'(fade_t);
        state_next = ops_pkg::ST_RD_DN_FADE;
      end
      ops_pkg::ST_RD_DN_FADE: begin
        rd_dly     = d_dn_fade;
        mac_cmd    = '{en: 1'b1, op: ops_pkg::MAC_LOAD};
        mac_x      = ops_pkg::MUL_X_W'(tap);
        mac_y      = ops_pkg::MUL_Y_W'(fade_w);
        state_next = ops_pkg::ST_FADE_DN;
      end
      ops_pkg::ST_FADE_DN: begin
        mac_cmd    = '{en: 1'b1, op: ops_pkg::MAC_ADD};
        mac_x      = ops_pkg::MUL_X_W'(tap);
        mac_y      = ops_pkg::MUL_Y_W'(fade_t);
        state_next = ops_pkg::ST_SUM_CLEAN;
      end
      ops_pkg::ST_SUM_CLEAN: begin
        mac_cmd    = '{en: 1'b1, op: ops_pkg::MAC_LOAD};
        mac_x      = clean_en ? ops_pkg::MUL_X_W'(s_reg) : '0;
        mac_y      = ops_pkg::MUL_Y_W'(1);
        state_next = ops_pkg::ST_SUM_UP;
      end
      ops_pkg::ST_SUM_UP: begin
        mac_cmd    = '{en: 1'b1, op: ops_pkg::MAC_ADD};
        mac_x      = up_en ? ops_pkg::MUL_X_W'(upv) : '0;
        mac_y      = ops_pkg::MUL_Y_W'(1);
        state_next = ops_pkg::ST_SUM_DN;
      end
      ops_pkg::ST_SUM_DN: begin
        mac_cmd    = '{en: 1'b1, op: ops_pkg::MAC_ADD};
        mac_x      = down_en ? ops_pkg::MUL_X_W'(downv) : '0;
        mac_y      = ops_pkg::MUL_Y_W'(1);
        state_next = ops_pkg::ST_SCALE;
      end
      ops_pkg::ST_SCALE: begin
        mac_cmd    = '{en: 1'b1, op: ops_pkg::MAC_LOAD};
        mac_x      = acc[ops_pkg::MUL_X_W-1:0];
        mac_y      = ops_pkg::recip(count);
        state_next = ops_pkg::ST_DONE;
      end
      ops_pkg::ST_DONE: begin
        // hold here while the previous result is still waiting
        if (!out_valid || mixed.ready) begin
          out_load   = 1'b1;
          state_next = ops_pkg::ST_IDLE;
        end
      end
      default: state_next = ops_pkg::ST_IDLE;
    endcase
  end

endmodule
